// ----- sv/rational_arithmetic_unit_macros.svh -----
// Assertion macros used by the top-level file to check this block.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rational arithmetic unit check failed");

// The consequent must hold in the cycle after the antecedent.
`define RAU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rational arithmetic unit check failed");

`endif

// ----- sv/rau_pkg.sv -----
package rau_pkg;

  localparam int DW = 64;
  localparam int DIV_STEPS = 63;
  localparam logic signed [DW-1:0] BIG = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef logic [3:0] mode_t;
  localparam mode_t MODE_ADD    = 4'd0;
  localparam mode_t MODE_SUB    = 4'd1;
  localparam mode_t MODE_MUL    = 4'd2;
  localparam mode_t MODE_DIV    = 4'd3;
  localparam mode_t MODE_ADDMIX = 4'd4;
  localparam mode_t MODE_DIVMIX = 4'd5;
  localparam mode_t MODE_RECIP  = 4'd6;
  localparam mode_t MODE_REDUCE = 4'd7;
  localparam mode_t MODE_MIX    = 4'd8;
  localparam mode_t MODE_UNMIX  = 4'd9;
  localparam mode_t MODE_LT     = 4'd10;
  localparam mode_t MODE_LE     = 4'd11;
  localparam mode_t MODE_EQ     = 4'd12;

  typedef logic [1:0] st_t;
  localparam st_t ST_OK   = 2'd0;
  localparam st_t ST_DIVZ = 2'd1;
  localparam st_t ST_ZDEN = 2'd2;

  typedef logic [4:0] op_t;
  localparam op_t OP_NOP       = 5'd0;
  localparam op_t OP_LOAD      = 5'd1;
  localparam op_t OP_MUL_START = 5'd2;
  localparam op_t OP_IMP_A     = 5'd3;
  localparam op_t OP_IMP_B     = 5'd4;
  localparam op_t OP_P1        = 5'd5;
  localparam op_t OP_P2        = 5'd6;
  localparam op_t OP_RN        = 5'd7;
  localparam op_t OP_RD        = 5'd8;
  localparam op_t OP_RN_SUM    = 5'd9;
  localparam op_t OP_CMP       = 5'd10;
  localparam op_t OP_RECIP     = 5'd11;
  localparam op_t OP_COPYA     = 5'd12;
  localparam op_t OP_SIGNFIX   = 5'd13;
  localparam op_t OP_GCD_INIT  = 5'd14;
  localparam op_t OP_GCD_STEP  = 5'd15;
  localparam op_t OP_GCD_END   = 5'd16;
  localparam op_t OP_DIV_START = 5'd17;
  localparam op_t OP_DIV_RN    = 5'd18;
  localparam op_t OP_DIV_RD    = 5'd19;
  localparam op_t OP_DIV_MIX   = 5'd20;
  localparam op_t OP_INT       = 5'd21;
  localparam op_t OP_OUT       = 5'd22;
  localparam op_t OP_OUT_ERR   = 5'd23;

  typedef logic [2:0] msel_t;
  localparam msel_t MSEL_AW_AD = 3'd0;
  localparam msel_t MSEL_BW_BD = 3'd1;
  localparam msel_t MSEL_AN_BD = 3'd2;
  localparam msel_t MSEL_BN_AD = 3'd3;
  localparam msel_t MSEL_AD_BD = 3'd4;
  localparam msel_t MSEL_AN_BN = 3'd5;
  localparam msel_t MSEL_AD_BN = 3'd6;

  typedef logic [1:0] dsel_t;
  localparam dsel_t DSEL_RN_G  = 2'd0;
  localparam dsel_t DSEL_RD_G  = 2'd1;
  localparam dsel_t DSEL_RN_RD = 2'd2;

  typedef struct packed {
    op_t   op;
    msel_t msel;
    dsel_t dsel;
    st_t   st;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  a_den_zero;
    logic  b_den_zero;
    logic  an_zero;
    logic  bn_zero;
    logic  mul_busy;
    logic  div_busy;
    logic  gcd_done;
  } sts_t;

  function automatic logic [DW-2:0] mag63(input logic signed [DW-1:0] x);
    logic [DW-1:0] m;
    m = x[DW-1] ? -x : x;
    return m[DW-2:0];
  endfunction

endpackage

// ----- sv/rational_arithmetic_unit.sv -----
// The datapath uses a shift-add multiplier, a binary gcd loop and a restoring divider
// (up to three quotients per item); an unknown mode or a zero denominator ends the item
// with zeroed result fields after the operand check. Throughput: one item at a time; busy
// is high from the accepted item until its result. Each result is shown for one cycle on
// out_valid and the receiver cannot stall it. Synchronous active-low reset returns the
// controller to idle.
`include "rational_arithmetic_unit_macros.svh"

module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [3:0]                      in_mode,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_whole,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_whole,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic                            out_valid,
  output logic signed [31:0]              out_res_whole,
  output logic signed [31:0]              out_res_num,
  output logic [30:0]                     out_res_den,
  output logic                            out_res_flag,
  output logic [1:0]                      out_status
);
  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  rau_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_mode       (in_mode),
    .in_a_whole    (in_a_whole),
    .in_a_num      (in_a_num),
    .in_a_den      (in_a_den),
    .in_b_whole    (in_b_whole),
    .in_b_num      (in_b_num),
    .in_b_den      (in_b_den),
    .out_valid     (out_valid),
    .out_res_whole (out_res_whole),
    .out_res_num   (out_res_num),
    .out_res_den   (out_res_den),
    .out_res_flag  (out_res_flag),
    .out_status    (out_status)
  );

  `RAU_ASSERT_NXT(a_busy_after_accept, start && !busy, busy)
  `RAU_ASSERT_IMP(a_idle_with_result, out_valid, !busy)
  `RAU_ASSERT_NXT(a_single_strobe, out_valid, !out_valid)
  `RAU_ASSERT_IMP(a_error_zero_fields, out_valid && (out_status != ST_OK),
                  (out_res_whole == 0) && (out_res_num == 0) && (out_res_den == 0))

endmodule

// ----- sv/rau_mul.sv -----
module rau_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [rau_pkg::DW-1:0] x,
  input  logic signed [rau_pkg::DW-1:0] y,
  output logic                         busy,
  output logic signed [rau_pkg::DW-1:0] p
);
  import rau_pkg::*;

  logic [DW-2:0] ux_r, ux_nxt, uy_r, uy_nxt, acc_r, acc_nxt;
  logic          big_r, big_nxt, ovf_r, ovf_nxt, neg_r, neg_nxt, busy_r, busy_nxt;
  logic [DW-1:0] sum;
  logic signed [DW-1:0] magp;

  always_comb begin
    ux_nxt   = ux_r;
    uy_nxt   = uy_r;
    acc_nxt  = acc_r;
    big_nxt  = big_r;
    ovf_nxt  = ovf_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    sum      = {1'b0, acc_r} + {1'b0, ux_r};
    if (start) begin
      ux_nxt   = mag63(x);
      uy_nxt   = mag63(y);
      acc_nxt  = '0;
      big_nxt  = 1'b0;
      ovf_nxt  = 1'b0;
      neg_nxt  = x[DW-1] ^ y[DW-1];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (uy_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (uy_r[0]) begin
          if (big_r || sum[DW-1]) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = sum[DW-2:0];
          end
        end
        ux_nxt  = {ux_r[DW-3:0], 1'b0};
        big_nxt = big_r | ux_r[DW-2];
        uy_nxt  = {1'b0, uy_r[DW-2:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    ux_r  <= ux_nxt;
    uy_r  <= uy_nxt;
    acc_r <= acc_nxt;
    big_r <= big_nxt;
    ovf_r <= ovf_nxt;
    neg_r <= neg_nxt;
  end

  assign magp = ovf_r ? BIG : $signed({1'b0, acc_r});
  assign p    = neg_r ? -magp : magp;
  assign busy = busy_r;

endmodule

// ----- sv/rau_div.sv -----
module rau_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [rau_pkg::DW-1:0] n,
  input  logic signed [rau_pkg::DW-1:0] d,
  output logic                         busy,
  output logic signed [rau_pkg::DW-1:0] q,
  output logic signed [rau_pkg::DW-1:0] r
);
  import rau_pkg::*;

  logic [DW-2:0] rem_r, rem_nxt, q_r, q_nxt, ud_r, ud_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt, busy_r, busy_nxt;
  logic [DW-1:0] t, diff;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    ud_nxt   = ud_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    t        = {rem_r, q_r[DW-2]};
    diff     = t - {1'b0, ud_r};
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = mag63(n);
      ud_nxt   = d[DW-2:0];
      cnt_nxt  = 6'(DIV_STEPS - 1);
      neg_nxt  = n[DW-1];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (t >= {1'b0, ud_r}) begin
        rem_nxt = diff[DW-2:0];
        q_nxt   = {q_r[DW-3:0], 1'b1};
      end else begin
        rem_nxt = t[DW-2:0];
        q_nxt   = {q_r[DW-3:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    ud_r  <= ud_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign q    = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign r    = neg_r ? -$signed({1'b0, rem_r}) : $signed({1'b0, rem_r});
  assign busy = busy_r;

endmodule

// ----- sv/rau_datapath.sv -----
module rau_datapath #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rau_pkg::cmd_t            cmd,
  output rau_pkg::sts_t            sts,
  input  logic [3:0]               in_mode,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_whole,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_whole,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic                     out_valid,
  output logic signed [31:0]       out_res_whole,
  output logic signed [31:0]       out_res_num,
  output logic [30:0]              out_res_den,
  output logic                     out_res_flag,
  output logic [1:0]               out_status
);
  import rau_pkg::*;

  localparam int EXT = DW - OPERAND_WIDTH;

  function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] x,
                                                input logic signed [DW-1:0] y);
    logic signed [DW:0] s;
    logic signed [DW:0] lim;
    s   = {x[DW-1], x} + {y[DW-1], y};
    lim = {1'b0, BIG};
    if (s > lim) return BIG;
    if (s < -lim) return -BIG;
    return s[DW-1:0];
  endfunction

  function automatic logic [31:0] s32(input logic signed [DW-1:0] x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [30:0] u31(input logic signed [DW-1:0] x);
    if (x < 0) return '0;
    if (x > 64'sd2147483647) return 31'h7FFF_FFFF;
    return x[30:0];
  endfunction

  mode_t mode_r, mode_nxt;
  logic signed [DW-1:0] aw_r, aw_nxt, an_r, an_nxt, ad_r, ad_nxt;
  logic signed [DW-1:0] bw_r, bw_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic signed [DW-1:0] p1_r, p1_nxt, p2_r, p2_nxt;
  logic signed [DW-1:0] rn_r, rn_nxt, rd_r, rd_nxt, rw_r, rw_nxt;
  logic                 flag_r, flag_nxt;
  logic [DW-2:0]        gu_r, gu_nxt, gv_r, gv_nxt, g_r, g_nxt;
  logic [5:0]           gk_r, gk_nxt;
  logic                 valid_r, valid_nxt;
  logic [31:0]          whole_r, whole_nxt, num_r, num_nxt;
  logic [30:0]          den_r, den_nxt;
  logic                 rflag_r, rflag_nxt;
  st_t                  status_r, status_nxt;

  logic signed [DW-1:0] aw_ext, an_ext, ad_ext, bw_ext, bn_ext, bd_ext;
  logic signed [DW-1:0] mul_x, mul_y, mul_p, div_n, div_d, div_q, div_r;
  logic                 mul_busy, div_busy, mul_start, div_start;

  assign aw_ext = {{EXT{in_a_whole[OPERAND_WIDTH-1]}}, in_a_whole};
  assign an_ext = {{EXT{in_a_num[OPERAND_WIDTH-1]}}, in_a_num};
  assign ad_ext = {{EXT{in_a_den[OPERAND_WIDTH-1]}}, in_a_den};
  assign bw_ext = {{EXT{in_b_whole[OPERAND_WIDTH-1]}}, in_b_whole};
  assign bn_ext = {{EXT{in_b_num[OPERAND_WIDTH-1]}}, in_b_num};
  assign bd_ext = {{EXT{in_b_den[OPERAND_WIDTH-1]}}, in_b_den};

  always_comb begin
    case (cmd.msel)
      MSEL_AW_AD: begin mul_x = aw_r; mul_y = ad_r; end
      MSEL_BW_BD: begin mul_x = bw_r; mul_y = bd_r; end
      MSEL_AN_BD: begin mul_x = an_r; mul_y = bd_r; end
      MSEL_BN_AD: begin mul_x = bn_r; mul_y = ad_r; end
      MSEL_AD_BD: begin mul_x = ad_r; mul_y = bd_r; end
      MSEL_AN_BN: begin mul_x = an_r; mul_y = bn_r; end
      MSEL_AD_BN: begin mul_x = ad_r; mul_y = bn_r; end
      default:    begin mul_x = '0;   mul_y = '0;   end
    endcase
    case (cmd.dsel)
      DSEL_RN_G:  begin div_n = rn_r; div_d = $signed({1'b0, g_r}); end
      DSEL_RD_G:  begin div_n = rd_r; div_d = $signed({1'b0, g_r}); end
      default:    begin div_n = rn_r; div_d = rd_r; end
    endcase
  end

  assign mul_start = (cmd.op == OP_MUL_START);
  assign div_start = (cmd.op == OP_DIV_START);

  rau_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .busy  (mul_busy),
    .p     (mul_p)
  );

  rau_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .busy  (div_busy),
    .q     (div_q),
    .r     (div_r)
  );

  always_comb begin
    mode_nxt   = mode_r;
    aw_nxt     = aw_r;
    an_nxt     = an_r;
    ad_nxt     = ad_r;
    bw_nxt     = bw_r;
    bn_nxt     = bn_r;
    bd_nxt     = bd_r;
    p1_nxt     = p1_r;
    p2_nxt     = p2_r;
    rn_nxt     = rn_r;
    rd_nxt     = rd_r;
    rw_nxt     = rw_r;
    flag_nxt   = flag_r;
    gu_nxt     = gu_r;
    gv_nxt     = gv_r;
    gk_nxt     = gk_r;
    g_nxt      = g_r;
    valid_nxt  = 1'b0;
    whole_nxt  = whole_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    rflag_nxt  = rflag_r;
    status_nxt = status_r;
    unique case (cmd.op)
      OP_LOAD: begin
        mode_nxt = in_mode;
        aw_nxt   = aw_ext;
        bw_nxt   = bw_ext;
        an_nxt   = ad_ext[DW-1] ? -an_ext : an_ext;
        ad_nxt   = ad_ext[DW-1] ? -ad_ext : ad_ext;
        bn_nxt   = bd_ext[DW-1] ? -bn_ext : bn_ext;
        bd_nxt   = bd_ext[DW-1] ? -bd_ext : bd_ext;
        rw_nxt   = '0;
        rn_nxt   = '0;
        rd_nxt   = '0;
        flag_nxt = 1'b0;
      end
      OP_IMP_A: an_nxt = sadd(an_r, mul_p);
      OP_IMP_B: bn_nxt = sadd(bn_r, mul_p);
      OP_P1:    p1_nxt = mul_p;
      OP_P2:    p2_nxt = mul_p;
      OP_RN:    rn_nxt = mul_p;
      OP_RD:    rd_nxt = mul_p;
      OP_RN_SUM: rn_nxt = sadd(p1_r, (mode_r == MODE_SUB) ? -p2_r : p2_r);
      OP_CMP: begin
        if (mode_r == MODE_LT) begin
          flag_nxt = (p1_r < p2_r);
        end else if (mode_r == MODE_LE) begin
          flag_nxt = (p1_r <= p2_r);
        end else begin
          flag_nxt = (p1_r == p2_r);
        end
      end
      OP_RECIP: begin
        rn_nxt = ad_r;
        rd_nxt = an_r;
      end
      OP_COPYA: begin
        rn_nxt = an_r;
        rd_nxt = ad_r;
      end
      OP_SIGNFIX: begin
        if (rd_r[DW-1]) begin
          rn_nxt = -rn_r;
          rd_nxt = -rd_r;
        end
      end
      OP_GCD_INIT: begin
        gu_nxt = mag63(rn_r);
        gv_nxt = rd_r[DW-2:0];
        gk_nxt = '0;
      end
      OP_GCD_STEP: begin
        if (!gu_r[0] && !gv_r[0]) begin
          gu_nxt = gu_r >> 1;
          gv_nxt = gv_r >> 1;
          gk_nxt = gk_r + 6'd1;
        end else if (!gu_r[0]) begin
          gu_nxt = gu_r >> 1;
        end else if (!gv_r[0]) begin
          gv_nxt = gv_r >> 1;
        end else if (gu_r >= gv_r) begin
          gu_nxt = gu_r - gv_r;
        end else begin
          gv_nxt = gv_r - gu_r;
        end
      end
      OP_GCD_END: g_nxt = (gu_r | gv_r) << gk_r;
      OP_DIV_RN: rn_nxt = div_q;
      OP_DIV_RD: rd_nxt = div_q;
      OP_DIV_MIX: begin
        rw_nxt = div_q;
        rn_nxt = div_r;
      end
      OP_INT: begin
        if (rd_r == 64'sd1) begin
          rw_nxt = rn_r;
          rn_nxt = '0;
        end
      end
      OP_OUT: begin
        valid_nxt  = 1'b1;
        whole_nxt  = s32(rw_r);
        num_nxt    = s32(rn_r);
        den_nxt    = u31(rd_r);
        rflag_nxt  = flag_r;
        status_nxt = ST_OK;
      end
      OP_OUT_ERR: begin
        valid_nxt  = 1'b1;
        whole_nxt  = '0;
        num_nxt    = '0;
        den_nxt    = '0;
        rflag_nxt  = 1'b0;
        status_nxt = cmd.st;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    mode_r   <= mode_nxt;
    aw_r     <= aw_nxt;
    an_r     <= an_nxt;
    ad_r     <= ad_nxt;
    bw_r     <= bw_nxt;
    bn_r     <= bn_nxt;
    bd_r     <= bd_nxt;
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    rn_r     <= rn_nxt;
    rd_r     <= rd_nxt;
    rw_r     <= rw_nxt;
    flag_r   <= flag_nxt;
    gu_r     <= gu_nxt;
    gv_r     <= gv_nxt;
    gk_r     <= gk_nxt;
    g_r      <= g_nxt;
    whole_r  <= whole_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    rflag_r  <= rflag_nxt;
    status_r <= status_nxt;
  end

  assign sts.mode       = mode_r;
  assign sts.a_den_zero = (ad_r == '0);
  assign sts.b_den_zero = (bd_r == '0);
  assign sts.an_zero    = (an_r == '0);
  assign sts.bn_zero    = (bn_r == '0);
  assign sts.mul_busy   = mul_busy;
  assign sts.div_busy   = div_busy;
  assign sts.gcd_done   = (gu_r == '0) || (gv_r == '0);

  assign out_valid     = valid_r;
  assign out_res_whole = whole_r;
  assign out_res_num   = num_r;
  assign out_res_den   = den_r;
  assign out_res_flag  = rflag_r;
  assign out_status    = status_r;

endmodule

// ----- sv/rau_ctrl.sv -----
module rau_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  rau_pkg::sts_t sts,
  output logic          busy,
  output rau_pkg::cmd_t cmd
);
  import rau_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CHECK  = 5'd1;
  localparam logic [4:0] S_IMPA_W = 5'd2;
  localparam logic [4:0] S_IMPB_S = 5'd3;
  localparam logic [4:0] S_IMPB_W = 5'd4;
  localparam logic [4:0] S_OPSEL  = 5'd5;
  localparam logic [4:0] S_P1_W   = 5'd6;
  localparam logic [4:0] S_P2_S   = 5'd7;
  localparam logic [4:0] S_P2_W   = 5'd8;
  localparam logic [4:0] S_SUM    = 5'd9;
  localparam logic [4:0] S_RN_W   = 5'd10;
  localparam logic [4:0] S_RD_S   = 5'd11;
  localparam logic [4:0] S_RD_W   = 5'd12;
  localparam logic [4:0] S_FIX    = 5'd13;
  localparam logic [4:0] S_POST   = 5'd14;
  localparam logic [4:0] S_GCD    = 5'd15;
  localparam logic [4:0] S_DG1_S  = 5'd16;
  localparam logic [4:0] S_DG1_W  = 5'd17;
  localparam logic [4:0] S_DG2_S  = 5'd18;
  localparam logic [4:0] S_DG2_W  = 5'd19;
  localparam logic [4:0] S_INT    = 5'd20;
  localparam logic [4:0] S_MIX_S  = 5'd21;
  localparam logic [4:0] S_MIX_W  = 5'd22;
  localparam logic [4:0] S_OUT    = 5'd23;

  logic [4:0] state_r, state_nxt;
  logic       binary, known, is_div, is_cmp;

  assign known  = (sts.mode <= MODE_EQ);
  assign is_cmp = (sts.mode >= MODE_LT) && known;
  assign binary = (sts.mode <= MODE_DIVMIX) || is_cmp;
  assign is_div = (sts.mode == MODE_DIV) || (sts.mode == MODE_DIVMIX);

  always_comb begin
    state_nxt = state_r;
    cmd       = '{op: OP_NOP, msel: MSEL_AW_AD, dsel: DSEL_RN_G, st: ST_OK};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!known) begin
          cmd.op    = OP_OUT_ERR;
          state_nxt = S_IDLE;
        end else if (sts.a_den_zero || (binary && sts.b_den_zero)) begin
          cmd.op    = OP_OUT_ERR;
          cmd.st    = ST_ZDEN;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_MUL_START;
          state_nxt = S_IMPA_W;
        end
      end
      S_IMPA_W: begin
        if (!sts.mul_busy) begin
          cmd.op    = OP_IMP_A;
          state_nxt = binary ? S_IMPB_S : S_OPSEL;
        end
      end
      S_IMPB_S: begin
        cmd.op    = OP_MUL_START;
        cmd.msel  = MSEL_BW_BD;
        state_nxt = S_IMPB_W;
      end
      S_IMPB_W: begin
        if (!sts.mul_busy) begin
          cmd.op    = OP_IMP_B;
          state_nxt = S_OPSEL;
        end
      end
      S_OPSEL: begin
        unique case (sts.mode) inside
          MODE_ADD, MODE_SUB, MODE_ADDMIX, MODE_LT, MODE_LE, MODE_EQ: begin
            cmd.op    = OP_MUL_START;
            cmd.msel  = MSEL_AN_BD;
            state_nxt = S_P1_W;
          end
          MODE_MUL: begin
            cmd.op    = OP_MUL_START;
            cmd.msel  = MSEL_AN_BN;
            state_nxt = S_RN_W;
          end
          MODE_DIV, MODE_DIVMIX: begin
            if (sts.bn_zero) begin
              cmd.op    = OP_OUT_ERR;
              cmd.st    = ST_DIVZ;
              state_nxt = S_IDLE;
            end else begin
              cmd.op    = OP_MUL_START;
              cmd.msel  = MSEL_AN_BD;
              state_nxt = S_RN_W;
            end
          end
          MODE_RECIP: begin
            if (sts.an_zero) begin
              cmd.op    = OP_OUT_ERR;
              cmd.st    = ST_DIVZ;
              state_nxt = S_IDLE;
            end else begin
              cmd.op    = OP_RECIP;
              state_nxt = S_FIX;
            end
          end
          default: begin
            cmd.op    = OP_COPYA;
            state_nxt = S_POST;
          end
        endcase
      end
      S_P1_W: begin
        if (!sts.mul_busy) begin
          cmd.op    = OP_P1;
          state_nxt = S_P2_S;
        end
      end
      S_P2_S: begin
        cmd.op    = OP_MUL_START;
        cmd.msel  = MSEL_BN_AD;
        state_nxt = S_P2_W;
      end
      S_P2_W: begin
        if (!sts.mul_busy) begin
          cmd.op    = OP_P2;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (is_cmp) begin
          cmd.op    = OP_CMP;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_RN_SUM;
          state_nxt = S_RD_S;
        end
      end
      S_RN_W: begin
        if (!sts.mul_busy) begin
          cmd.op    = OP_RN;
          state_nxt = S_RD_S;
        end
      end
      S_RD_S: begin
        cmd.op    = OP_MUL_START;
        cmd.msel  = is_div ? MSEL_AD_BN : MSEL_AD_BD;
        state_nxt = S_RD_W;
      end
      S_RD_W: begin
        if (!sts.mul_busy) begin
          cmd.op    = OP_RD;
          state_nxt = is_div ? S_FIX : S_POST;
        end
      end
      S_FIX: begin
        cmd.op    = OP_SIGNFIX;
        state_nxt = S_POST;
      end
      S_POST: begin
        if ((sts.mode == MODE_RECIP) || (sts.mode == MODE_UNMIX)) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end else if (sts.mode == MODE_MIX) begin
          cmd.op    = OP_DIV_START;
          cmd.dsel  = DSEL_RN_RD;
          state_nxt = S_MIX_W;
        end else begin
          cmd.op    = OP_GCD_INIT;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.op    = OP_GCD_END;
          state_nxt = S_DG1_S;
        end else begin
          cmd.op = OP_GCD_STEP;
        end
      end
      S_DG1_S: begin
        cmd.op    = OP_DIV_START;
        cmd.dsel  = DSEL_RN_G;
        state_nxt = S_DG1_W;
      end
      S_DG1_W: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_DIV_RN;
          state_nxt = S_DG2_S;
        end
      end
      S_DG2_S: begin
        cmd.op    = OP_DIV_START;
        cmd.dsel  = DSEL_RD_G;
        state_nxt = S_DG2_W;
      end
      S_DG2_W: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_DIV_RD;
          state_nxt = ((sts.mode == MODE_ADDMIX) || is_div && (sts.mode == MODE_DIVMIX))
                      ? S_MIX_S : S_INT;
        end
      end
      S_INT: begin
        cmd.op    = OP_INT;
        state_nxt = S_OUT;
      end
      S_MIX_S: begin
        cmd.op    = OP_DIV_START;
        cmd.dsel  = DSEL_RN_RD;
        state_nxt = S_MIX_W;
      end
      S_MIX_W: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_DIV_MIX;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        cmd.op    = OP_OUT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
